>>> hw/rtl/phase_slip_split_and_debias_assert.svh
// Assertion macros shared by the checker of the slip splitter.
// Both macros use the clock and reset names of the top level's ports.
`ifndef PHASE_SLIP_SPLIT_AND_DEBIAS_ASSERT_SVH
`define PHASE_SLIP_SPLIT_AND_DEBIAS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/psd_pkg.sv
package psd_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int MAX_SAMPLES = 64;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int ARC_W       = IDX_W;
	localparam int SUM_W       = SAMPLE_W + IDX_W;
	localparam int THR_W       = 31;
	localparam int DIV_STEP_W  = $clog2(SUM_W);

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLOSE,
		ST_DIV_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT_REC,
		ST_EMIT_MEAN,
		ST_EMIT_CALC,
		ST_EMIT_OUT
	} psd_state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] tdiff;
		logic [ARC_W-1:0]           arc;
	} psd_rec_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        cnt;
	} psd_arc_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} psd_div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] quotient;
	} psd_div_rsp_t;

endpackage

>>> hw/rtl/phase_slip_split_and_debias.sv
// Loading takes one sample per cycle; the sample that closes a run stalls the input until its last result is taken.
// Closing then writes the last arc, and the shared divider forms the mean of each
// arc in turn; each result then needs two dependent memory reads (record, then mean).
// Reset clears the run state and sets the slip threshold to 0.45 cycles.
module phase_slip_split_and_debias import psd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] dd_sample,
	input  logic                       last_in,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [SAMPLE_W-1:0] debiased_dd,
	output logic signed [SAMPLE_W-1:0] triple_diff,
	output logic [ARC_W-1:0]           arc_index,
	output logic                       last_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [THR_W-1:0]           slip_threshold
);

	function automatic logic signed [SAMPLE_W-1:0] sat33(input logic signed [SAMPLE_W:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
			r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	psd_state_t state_q, state_d;

	logic [THR_W-1:0]           thr_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ARC_W-1:0]           arc_q;
	logic [CNT_W-1:0]           loaded_q;
	logic [ARC_W-1:0]           div_arc_q;
	logic [IDX_W-1:0]           emit_k_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] debiased_q;
	logic signed [SAMPLE_W-1:0] tdiff_q;
	logic [ARC_W-1:0]           arc_out_q;
	logic                       last_q;

	logic                       in_acc;
	logic                       out_acc;
	logic [IDX_W-1:0]           idx;
	logic                       first;
	logic                       close_run;
	logic signed [SAMPLE_W:0]   td_wide;
	logic signed [SAMPLE_W-1:0] td;
	logic [SAMPLE_W-1:0]        td_mag;
	logic                       slip;
	logic [ARC_W-1:0]           new_arc;
	logic signed [SUM_W-1:0]    sample_ext;
	logic                       div_last;

	logic                       rec_wr_en;
	psd_rec_t                   rec_wr;
	psd_rec_t                   rec_rd;
	logic                       arc_wr_en;
	psd_arc_t                   arc_wr;
	psd_arc_t                   arc_rd;
	logic                       mean_wr_en;
	logic signed [SAMPLE_W-1:0] mean_rd;
	psd_div_req_t               div_req;
	psd_div_rsp_t               div_rsp;
	logic signed [SAMPLE_W:0]   deb_wide;

	assign in_acc  = sample_valid && !sample_stall;
	assign out_acc = out_valid_q && !result_stall;

	assign idx       = loaded_q[IDX_W-1:0];
	assign first     = (loaded_q == '0);
	assign close_run = last_in || (idx == IDX_W'(MAX_SAMPLES - 1));
	assign td_wide   = {dd_sample[SAMPLE_W-1], dd_sample} - {prev_q[SAMPLE_W-1], prev_q};
	assign td        = first ? '0 : sat33(td_wide);
	assign td_mag    = td[SAMPLE_W-1] ? SAMPLE_W'(-td) : SAMPLE_W'(td);
	assign slip      = !first && (td_mag > {1'b0, thr_q}) && (arc_q != ARC_W'(MAX_SAMPLES - 1));
	assign new_arc   = slip ? arc_q + ARC_W'(1) : arc_q;
	assign sample_ext = {{(SUM_W-SAMPLE_W){dd_sample[SAMPLE_W-1]}}, dd_sample};
	assign div_last  = (div_arc_q == arc_q);

	assign rec_wr.sample = dd_sample;
	assign rec_wr.tdiff  = td;
	assign rec_wr.arc    = new_arc;
	assign arc_wr.sum    = sum_q;
	assign arc_wr.cnt    = cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && close_run) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE:     state_d = ST_DIV_RD;
			ST_DIV_RD:    state_d = ST_DIV_GO;
			ST_DIV_GO:    state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = div_last ? ST_EMIT_REC : ST_DIV_RD;
				end
			end
			ST_EMIT_REC:  state_d = ST_EMIT_MEAN;
			ST_EMIT_MEAN: state_d = ST_EMIT_CALC;
			ST_EMIT_CALC: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (out_acc) begin
					state_d = last_q ? ST_LOAD : ST_EMIT_REC;
				end
			end
			default:      state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		sample_stall  = (state_q != ST_LOAD);
		rec_wr_en     = in_acc;
		arc_wr_en     = (in_acc && slip) || (state_q == ST_CLOSE);
		mean_wr_en    = (state_q == ST_DIV_WAIT) && div_rsp.done;
		div_req.start = (state_q == ST_DIV_GO);
	end

	assign div_req.neg      = arc_rd.sum[SUM_W-1];
	assign div_req.dividend = arc_rd.sum[SUM_W-1] ? SUM_W'(-arc_rd.sum) : SUM_W'(arc_rd.sum);
	assign div_req.divisor  = arc_rd.cnt;

	psd_ram #(.WIDTH($bits(psd_rec_t)), .DEPTH(MAX_SAMPLES)) u_rec_ram (
		.clk     (clk),
		.wr_en   (rec_wr_en),
		.wr_addr (idx),
		.wr_data (rec_wr),
		.rd_addr (emit_k_q),
		.rd_data (rec_rd)
	);

	psd_ram #(.WIDTH($bits(psd_arc_t)), .DEPTH(MAX_SAMPLES)) u_arc_ram (
		.clk     (clk),
		.wr_en   (arc_wr_en),
		.wr_addr (arc_q),
		.wr_data (arc_wr),
		.rd_addr (div_arc_q),
		.rd_data (arc_rd)
	);

	psd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_mean_ram (
		.clk     (clk),
		.wr_en   (mean_wr_en),
		.wr_addr (div_arc_q),
		.wr_data (div_rsp.quotient),
		.rd_addr (rec_rd.arc),
		.rd_data (mean_rd)
	);

	psd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign deb_wide = {rec_rd.sample[SAMPLE_W-1], rec_rd.sample} - {mean_rd[SAMPLE_W-1], mean_rd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			thr_q       <= THR_RESET;
			prev_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			arc_q       <= '0;
			loaded_q    <= '0;
			div_arc_q   <= '0;
			emit_k_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				thr_q <= slip_threshold;
			end
			if (in_acc) begin
				prev_q   <= dd_sample;
				loaded_q <= loaded_q + CNT_W'(1);
				arc_q    <= new_arc;
				if (slip) begin
					sum_q <= sample_ext;
					cnt_q <= CNT_W'(1);
				end else begin
					sum_q <= sum_q + sample_ext;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_CLOSE) begin
				div_arc_q <= '0;
			end else if (mean_wr_en) begin
				if (div_last) begin
					emit_k_q <= '0;
				end else begin
					div_arc_q <= div_arc_q + ARC_W'(1);
				end
			end
			if (state_q == ST_EMIT_CALC) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
				if (last_q) begin
					prev_q   <= '0;
					sum_q    <= '0;
					cnt_q    <= '0;
					arc_q    <= '0;
					loaded_q <= '0;
				end else begin
					emit_k_q <= emit_k_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_CALC) begin
			debiased_q <= sat33(deb_wide);
			tdiff_q    <= rec_rd.tdiff;
			arc_out_q  <= rec_rd.arc;
			last_q     <= (CNT_W'(emit_k_q) + CNT_W'(1) == loaded_q);
		end
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign debiased_dd  = debiased_q;
	assign triple_diff  = tdiff_q;
	assign arc_index    = arc_out_q;
	assign last_out     = last_q;

endmodule

>>> hw/rtl/psd_ram.sv
module psd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hw/rtl/psd_div.sv
module psd_div import psd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  psd_div_req_t req,
	output psd_div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      divisor_q;
	logic [SUM_W-1:0]      dvd_q;
	logic [CNT_W:0]        trial;
	logic [CNT_W:0]        diff;
	logic                  qbit;
	logic [SAMPLE_W-1:0]   qmag;

	// One quotient bit per cycle, restoring division on magnitudes.
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign qbit  = ~diff[CNT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
			neg_q     <= req.neg;
			rem_q     <= '0;
			step_q    <= DIV_STEP_W'(SUM_W - 1);
		end else if (busy_q) begin
			rem_q  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dvd_q  <= {dvd_q[SUM_W-2:0], qbit};
			step_q <= step_q - DIV_STEP_W'(1);
		end
	end

	assign qmag         = dvd_q[SAMPLE_W-1:0];
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -qmag : qmag;

endmodule

>>> hw/rtl/psd_checker.sv
`include "phase_slip_split_and_debias_assert.svh"

module psd_checker import psd_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       sample_valid,
	input logic                       sample_stall,
	input logic                       last_in,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic signed [SAMPLE_W-1:0] debiased_dd,
	input logic signed [SAMPLE_W-1:0] triple_diff,
	input logic [ARC_W-1:0]           arc_index,
	input logic                       last_out
);

	// A stalled result transaction must hold its payload.
	`PSD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(debiased_dd) && $stable(triple_diff) && $stable(arc_index) && $stable(last_out), "stalled result changed")

	// No sample is taken while results of a run are pending.
	`PSD_ASSERT_NOW(a_no_load_during_emit, result_valid, sample_stall, "input open during emission")

	// The closing sample of a run stops the input in the next cycle.
	`PSD_ASSERT_NEXT(a_close_stalls, sample_valid && !sample_stall && last_in, sample_stall, "input open after closing sample")

	// After the final result of a run no further result follows at once.
	`PSD_ASSERT_NEXT(a_run_ends, result_valid && !result_stall && last_out, !result_valid, "result after final result")

endmodule

bind phase_slip_split_and_debias psd_checker u_psd_checker (.*);

>>> sim/phase_slip_split_and_debias_test.sv
module phase_slip_split_and_debias_test import psd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_SAMPLES = 410;
	localparam int CALM_AFTER = 340;
	localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic [THR_W-1:0] THR_FULL = {THR_W{1'b1}};

	typedef struct {
		logic signed [SAMPLE_W-1:0] debiased;
		logic signed [SAMPLE_W-1:0] tdiff;
		logic [ARC_W-1:0]           arc;
		logic                       last;
	} debias_out_t;

	class slip_arc_tracker;
		logic [THR_W-1:0]           threshold;
		logic signed [SAMPLE_W-1:0] raw_q [MAX_SAMPLES];
		logic signed [SAMPLE_W-1:0] tdiff_q [MAX_SAMPLES];
		int                         arc_of [MAX_SAMPLES];
		longint                     arc_total [MAX_SAMPLES];
		int                         arc_len [MAX_SAMPLES];
		logic signed [SAMPLE_W-1:0] prior;
		int                         arc_now;
		int                         loaded;
		debias_out_t                awaited [$];
		int                         errors;
		int                         samples;
		int                         runs;
		int                         checked;
		int                         full_runs;
		int                         widest;

		function new();
			threshold = THR_RESET;
			clear_run();
		endfunction

		static function logic signed [SAMPLE_W-1:0] clip(longint v);
			if (v > 64'sd2147483647)
				return Q_MAX;
			if (v < -64'sd2147483648)
				return Q_MIN;
			return v[SAMPLE_W-1:0];
		endfunction

		function void clear_run();
			foreach (arc_total[k]) begin
				arc_total[k] = 0;
				arc_len[k] = 0;
			end
			prior = '0;
			arc_now = 0;
			loaded = 0;
		endfunction

		function void load_sample(logic signed [SAMPLE_W-1:0] s, logic closing);
			logic signed [SAMPLE_W-1:0] td;
			longint mag;
			longint mean [MAX_SAMPLES];
			debias_out_t r;
			td = '0;
			samples++;
			if (loaded > 0) begin
				td = clip(longint'(s) - longint'(prior));
				mag = (td < 0) ? -longint'(td) : longint'(td);
				if (mag > longint'(threshold) && arc_now < MAX_SAMPLES - 1)
					arc_now++;
			end
			raw_q[loaded] = s;
			tdiff_q[loaded] = td;
			arc_of[loaded] = arc_now;
			arc_total[arc_now] += longint'(s);
			arc_len[arc_now]++;
			prior = s;
			loaded++;
			if (!closing && loaded < MAX_SAMPLES)
				return;
			for (int k = 0; k <= arc_now; k++)
				mean[k] = arc_total[k] / arc_len[k];
			for (int k = 0; k < loaded; k++) begin
				r.debiased = clip(longint'(raw_q[k]) - mean[arc_of[k]]);
				r.tdiff = tdiff_q[k];
				r.arc = ARC_W'(arc_of[k]);
				r.last = (k == loaded - 1);
				awaited.insert(awaited.size(), r);
			end
			runs++;
			if (loaded == MAX_SAMPLES)
				full_runs++;
			if (arc_now + 1 > widest)
				widest = arc_now + 1;
			clear_run();
		endfunction

		function void field_diff(string name, logic signed [SAMPLE_W-1:0] want,
				logic signed [SAMPLE_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void compare_output(logic signed [SAMPLE_W-1:0] dbd,
				logic signed [SAMPLE_W-1:0] tdf, logic [ARC_W-1:0] arc, logic last);
			debias_out_t e;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: debiased %0d, triple diff %0d,",
					$time, dbd, tdf);
				$display("%0t: arc %0d, last %0b", $time, arc, last);
				return;
			end
			e = awaited.pop_front();
			checked++;
			field_diff("debiased_dd", e.debiased, dbd);
			field_diff("triple_diff", e.tdiff, tdf);
			field_diff("arc_index", e.arc, arc);
			field_diff("last_out", e.last, last);
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] dd_sample = '0;
	logic                       last_in = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] debiased_dd;
	logic signed [SAMPLE_W-1:0] triple_diff;
	logic [ARC_W-1:0]           arc_index;
	logic                       last_out;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [THR_W-1:0]           slip_threshold = THR_RESET;
	bit                         calm = 1'b0;

	slip_arc_tracker sb = new();

	phase_slip_split_and_debias dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.dd_sample      (dd_sample),
		.last_in        (last_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.debiased_dd    (debiased_dd),
		.triple_diff    (triple_diff),
		.arc_index      (arc_index),
		.last_out       (last_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.slip_threshold (slip_threshold)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.compare_output(debiased_dd, triple_diff, arc_index, last_out);
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Timed out after %0d cycles with %0d results outstanding",
			LIMIT_CYCLES, sb.awaited.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic closing);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		dd_sample <= value;
		last_in <= closing;
		do @(posedge clk); while (sample_stall);
		sb.load_sample(value, closing);
	endtask

	task automatic send_run(input logic signed [SAMPLE_W-1:0] vals [$]);
		foreach (vals[i])
			send_sample(vals[i], i == vals.size() - 1);
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] value);
		sample_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		slip_threshold <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.threshold = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode,
			logic signed [SAMPLE_W-1:0] prev, logic [THR_W-1:0] thr);
		longint step;
		case (mode)
			0: return $urandom;
			3: begin
				case ($urandom_range(0, 5))
					0: return Q_MIN;
					1: return Q_MAX;
					2: return '0;
					3: return -32'sd1;
					4: return 32'sd1;
					default: return $urandom;
				endcase
			end
			default: begin
				case ($urandom_range(0, 3))
					0: step = longint'(thr);
					1: step = longint'(thr) + 1;
					2: step = $urandom_range(0, 3);
					default: step = longint'($urandom_range(0, thr)) + longint'($urandom_range(0, thr));
				endcase
				if ($urandom_range(0, 1) == 1)
					step = -step;
				return slip_arc_tracker::clip(longint'(prev) + step);
			end
		endcase
	endfunction

	initial begin
		logic signed [SAMPLE_W-1:0] run_q [$];
		logic signed [SAMPLE_W-1:0] value;
		logic closing;
		int len;
		int mode;
		int sent;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_q = '{Q_MAX};
		send_run(run_q);
		run_q = '{32'sd0, 32'sd29491, 32'sd58983, Q_MIN, Q_MAX};
		send_run(run_q);
		set_threshold('0);
		run_q = '{32'sd5, 32'sd5, 32'sd6, -32'sd1};
		send_run(run_q);
		set_threshold(THR_FULL);
		run_q = '{Q_MAX, Q_MIN, Q_MAX};
		send_run(run_q);
		run_q = '{Q_MAX, Q_MAX, Q_MAX, 32'sd0, -Q_MAX};
		send_run(run_q);
		run_q = '{-Q_MAX, -Q_MAX, -Q_MAX, 32'sd0, Q_MAX};
		send_run(run_q);
		run_q = '{-32'sd1, -32'sd2};
		send_run(run_q);

		sent = 0;
		while (sent < RANDOM_SAMPLES) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0: set_threshold('0);
					1: set_threshold(THR_FULL);
					2: set_threshold(THR_RESET);
					3: set_threshold(THR_W'($urandom_range(0, 200000)));
					default: set_threshold(THR_W'($urandom));
				endcase
			end
			case ($urandom_range(0, 9))
				0: len = MAX_SAMPLES;
				1: len = $urandom_range(13, 40);
				default: len = $urandom_range(1, 12);
			endcase
			mode = $urandom_range(0, 4);
			value = $urandom;
			for (int i = 0; i < len; i++) begin
				value = pick_sample(mode, value, sb.threshold);
				closing = (i == len - 1) && (len < MAX_SAMPLES || $urandom_range(0, 1) == 1);
				send_sample(value, closing);
				sent++;
				calm = (sent > CALM_AFTER);
			end
		end

		sample_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d results from %0d samples in %0d runs (%0d filled the store).",
			sb.checked, sb.samples, sb.runs, sb.full_runs);
		$display("Thresholds ranged from zero to full scale; the widest run split into %0d arcs.",
			sb.widest);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
